/* hdl/amgs_pkg.sv */
// amgs_pkg: shared types and constants of the adjacency matrix graph store
// payload structs for the request and response channels, command and csr codes
// no dependencies
package amgs_pkg;

   localparam int VERTEX_BITS    = 5;
   localparam int COMMAND_BITS   = 3;
   localparam int VALUE_BITS     = 13;
   localparam int EDGE_MODE_BITS = 2;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = 13'h1fff;

   localparam logic [COMMAND_BITS-1:0] CMD_CLEAR     = 3'd0;
   localparam logic [COMMAND_BITS-1:0] CMD_ADD_EDGE  = 3'd1;
   localparam logic [COMMAND_BITS-1:0] CMD_ADJACENT  = 3'd2;
   localparam logic [COMMAND_BITS-1:0] CMD_DEGREE    = 3'd3;
   localparam logic [COMMAND_BITS-1:0] CMD_IN_OUT    = 3'd4;
   localparam logic [COMMAND_BITS-1:0] CMD_IN_DEG    = 3'd5;
   localparam logic [COMMAND_BITS-1:0] CMD_OUT_DEG   = 3'd6;
   localparam logic [COMMAND_BITS-1:0] CMD_NEIGHBORS = 3'd7;

   localparam logic [EDGE_MODE_BITS-1:0] MODE_SET_SYM    = 2'd0;
   localparam logic [EDGE_MODE_BITS-1:0] MODE_SET_DIR    = 2'd1;
   localparam logic [EDGE_MODE_BITS-1:0] MODE_INC_UNDIR  = 2'd2;
   localparam logic [EDGE_MODE_BITS-1:0] MODE_INC_DIR    = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_MODE    = 1'd1;

   localparam logic [VERTEX_BITS-1:0]    VERTEX_COUNT_RESET = 5'd16;
   localparam logic [EDGE_MODE_BITS-1:0] EDGE_MODE_RESET    = MODE_INC_UNDIR;

   typedef struct packed {
      logic [COMMAND_BITS-1:0] command;
      logic [VERTEX_BITS-1:0]  row_vertex;
      logic [VERTEX_BITS-1:0]  column_vertex;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last;
      logic                  empty_res;
      logic                  error;
   } rsp_payload_type;

endpackage

/* hdl/amgs_stream_if.sv */
// amgs_stream_if: valid/ready channel carrying one payload per transfer
// payload type is a parameter, normally a struct from amgs_pkg
interface amgs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/amgs_count_ram.sv */
// amgs_count_ram: single write port, single read port memory of edge counts
// read data registered, valid in the cycle after the read address; no dependencies
module amgs_count_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/adjacency_matrix_graph_store_core.sv */
// adjacency_matrix_graph_store_core: edge-count matrix with edge updates and queries
// uses amgs_pkg, amgs_stream_if and amgs_count_ram
//
// usage
//  req_chan carries command, row_vertex and column_vertex; rsp_chan returns value,
//  last, empty_res and error. csr_write_enable with csr_index 0 writes vertex_count,
//  index 1 writes edge_mode; write only while no command is in flight.
//  one command is handled at a time; every command gives at least one response,
//  the final one with last set. neighbour listings give one response per neighbour.
// sequencing (n = active vertex count)
//  add edge reads and writes its entry, then the mirrored one in modes 0 and 2
//  when the vertices differ; adjacency reads one entry; scans read n entries, 2n
//  for in plus out. clear sweeps all 2^(2*clog2(MAX_VERTICES)) entries (256 by
//  default), one a cycle. single read port: one entry per cycle unless stalled.
// reset
//  runs the same sweep over the memory with req_chan.ready low; csr writes are
//  taken during the sweep. registers return to 16 and mode 2.
// stalls
//  a response waits in an output register while the next command is taken;
//  a neighbour scan holds in place when it finds a further neighbour while the receiver withholds ready.
module adjacency_matrix_graph_store_core #(
   parameter int MAX_VERTICES = 16,
   parameter int COUNT_BITS   = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   amgs_stream_if.sink                            req_chan,
   amgs_stream_if.source                          rsp_chan,
   input  logic                                   csr_write_enable,
   input  logic [amgs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [amgs_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);
   localparam int IDX_W  = $clog2(MAX_VERTICES);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int VW     = amgs_pkg::VERTEX_BITS;
   localparam int CMP_W  = (CNT_W > VW) ? CNT_W : VW;
   localparam int VB     = amgs_pkg::VALUE_BITS;
   localparam int SUM_W  = ((COUNT_BITS + 1 > VB) ? COUNT_BITS + 1 : VB) + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [ADDR_W-1:0]     ADDR_LAST = {ADDR_W{1'b1}};

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CLEAR   = 3'd1;
   localparam logic [2:0] ST_EDGE_RD = 3'd2;
   localparam logic [2:0] ST_EDGE_WR = 3'd3;
   localparam logic [2:0] ST_ADJ_RD  = 3'd4;
   localparam logic [2:0] ST_ADJ_CHK = 3'd5;
   localparam logic [2:0] ST_SCAN    = 3'd6;
   localparam logic [2:0] ST_EMIT    = 3'd7;

   // control state
   logic [2:0]                            state_ff, state_in;
   logic [ADDR_W-1:0]                     clr_addr_ff, clr_addr_in;
   logic                                  clear_reply_ff, clear_reply_in;
   logic                                  second_ff, second_in;
   logic                                  col_pass_ff, col_pass_in;
   logic [CNT_W-1:0]                      idx_ff, idx_in;
   logic                                  issued_ff, issued_in;
   logic                                  pend_valid_ff, pend_valid_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                         vertex_count_ff, vertex_count_in;
   logic [amgs_pkg::EDGE_MODE_BITS-1:0]   edge_mode_ff, edge_mode_in;

   // item payload
   logic [amgs_pkg::COMMAND_BITS-1:0]     cmd_ff, cmd_in;
   logic [IDX_W-1:0]                      r_ff, r_in;
   logic [IDX_W-1:0]                      c_ff, c_in;
   logic [IDX_W-1:0]                      didx_ff, didx_in;
   logic [IDX_W-1:0]                      pend_idx_ff, pend_idx_in;
   logic [VB-1:0]                         acc_ff, acc_in;
   logic [VB-1:0]                         res_value_ff, res_value_in;
   logic                                  res_empty_ff, res_empty_in;
   logic                                  res_error_ff, res_error_in;
   amgs_pkg::rsp_payload_type             rsp_data_ff, rsp_data_in;

   // memory port
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [COUNT_BITS-1:0]   wr_data;
   logic [ADDR_W-1:0]       rd_addr;
   logic [COUNT_BITS-1:0]   rd_data;

   // decode
   logic [CMP_W-1:0]        active_n;
   logic [CMP_W-1:0]        row_ext, col_ext;
   logic                    row_ok, col_ok, need_col;
   logic                    req_fire, out_free;
   logic                    nbr_cmd, stall, consume, scan_more, dbl;
   logic [SUM_W-1:0]        sum;
   logic [ADDR_W-1:0]       edge_addr, scan_addr, held_addr;
   logic                    edge_again;

   amgs_count_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (COUNT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      active_n = (CMP_W'(vertex_count_ff) > CMP_W'(MAX_VERTICES))
               ? CMP_W'(MAX_VERTICES) : CMP_W'(vertex_count_ff);
      row_ext  = CMP_W'(req_chan.payload.row_vertex);
      col_ext  = CMP_W'(req_chan.payload.column_vertex);
      row_ok   = (row_ext != '0) && (row_ext <= active_n);
      col_ok   = (col_ext != '0) && (col_ext <= active_n);
      need_col = (req_chan.payload.command == amgs_pkg::CMD_ADD_EDGE)
              || (req_chan.payload.command == amgs_pkg::CMD_ADJACENT);
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // scan datapath
   always_comb begin
      nbr_cmd   = (cmd_ff == amgs_pkg::CMD_NEIGHBORS);
      stall     = (state_ff == ST_SCAN) && issued_ff && nbr_cmd
               && (rd_data != '0) && pend_valid_ff && !out_free;
      consume   = (state_ff == ST_SCAN) && issued_ff && !stall;
      scan_more = CMP_W'(idx_ff) < active_n;
      dbl       = (cmd_ff == amgs_pkg::CMD_DEGREE) && !col_pass_ff && (didx_ff == r_ff);
      sum       = SUM_W'(acc_ff) + SUM_W'(rd_data) + (dbl ? SUM_W'(rd_data) : '0);
      scan_addr = col_pass_ff ? {idx_ff[IDX_W-1:0], r_ff} : {r_ff, idx_ff[IDX_W-1:0]};
      held_addr = col_pass_ff ? {didx_ff, r_ff} : {r_ff, didx_ff};
      edge_addr = second_ff ? {c_ff, r_ff} : {r_ff, c_ff};
      edge_again = !second_ff && (r_ff != c_ff)
                && ((edge_mode_ff == amgs_pkg::MODE_SET_SYM)
                 || (edge_mode_ff == amgs_pkg::MODE_INC_UNDIR));
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      clear_reply_in = clear_reply_ff;
      second_in      = second_ff;
      col_pass_in    = col_pass_ff;
      idx_in         = idx_ff;
      issued_in      = issued_ff;
      pend_valid_in  = pend_valid_ff;
      cmd_in         = cmd_ff;
      r_in           = r_ff;
      c_in           = c_ff;
      didx_in        = didx_ff;
      pend_idx_in    = pend_idx_ff;
      acc_in         = acc_ff;
      res_value_in   = res_value_ff;
      res_empty_in   = res_empty_ff;
      res_error_in   = res_error_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in    = rsp_data_ff;
      wr_en          = 1'b0;
      wr_addr        = edge_addr;
      wr_data        = '0;
      rd_addr        = edge_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in       = req_chan.payload.command;
               r_in         = IDX_W'(row_ext - CMP_W'(1));
               c_in         = IDX_W'(col_ext - CMP_W'(1));
               res_value_in = '0;
               res_empty_in = 1'b0;
               res_error_in = 1'b0;
               second_in    = 1'b0;
               idx_in       = '0;
               issued_in    = 1'b0;
               acc_in       = '0;
               pend_valid_in = 1'b0;
               col_pass_in  = (req_chan.payload.command == amgs_pkg::CMD_IN_DEG);
               priority if (req_chan.payload.command == amgs_pkg::CMD_CLEAR) begin
                  clr_addr_in    = '0;
                  clear_reply_in = 1'b1;
                  state_in       = ST_CLEAR;
               end else if (!row_ok || (need_col && !col_ok)) begin
                  res_error_in = 1'b1;
                  state_in     = ST_EMIT;
               end else if (req_chan.payload.command == amgs_pkg::CMD_ADD_EDGE) begin
                  state_in = ST_EDGE_RD;
               end else if (req_chan.payload.command == amgs_pkg::CMD_ADJACENT) begin
                  state_in = ST_ADJ_RD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_LAST) begin
               state_in       = clear_reply_ff ? ST_EMIT : ST_IDLE;
               clear_reply_in = 1'b0;
            end
         end
         ST_EDGE_RD: begin
            state_in = ST_EDGE_WR;
         end
         ST_EDGE_WR: begin
            wr_en = 1'b1;
            if ((edge_mode_ff == amgs_pkg::MODE_SET_SYM)
                || (edge_mode_ff == amgs_pkg::MODE_SET_DIR)) begin
               wr_data = COUNT_BITS'(1);
            end else begin
               wr_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + COUNT_BITS'(1);
            end
            if (edge_again) begin
               second_in = 1'b1;
               state_in  = ST_EDGE_RD;
            end else begin
               state_in  = ST_EMIT;
            end
         end
         ST_ADJ_RD: begin
            state_in = ST_ADJ_CHK;
         end
         ST_ADJ_CHK: begin
            res_value_in = VB'(rd_data != '0);
            state_in     = ST_EMIT;
         end
         ST_SCAN: begin
            rd_addr = stall ? held_addr : scan_addr;
            if (consume) begin
               if (nbr_cmd) begin
                  if (rd_data != '0) begin
                     if (pend_valid_ff) begin
                        // earlier neighbour is not the last one
                        rsp_valid_in            = 1'b1;
                        rsp_data_in.value       = VB'(pend_idx_ff) + VB'(1);
                        rsp_data_in.last        = 1'b0;
                        rsp_data_in.empty_res   = 1'b0;
                        rsp_data_in.error       = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_idx_in   = didx_ff;
                  end
               end else begin
                  acc_in = (sum > SUM_W'(amgs_pkg::VALUE_MAX)) ? amgs_pkg::VALUE_MAX : VB'(sum);
               end
            end
            if (!stall) begin
               if (scan_more) begin
                  didx_in   = idx_ff[IDX_W-1:0];
                  idx_in    = idx_ff + CNT_W'(1);
                  issued_in = 1'b1;
               end else begin
                  issued_in = 1'b0;
               end
            end
            if (!issued_ff && !scan_more) begin
               if ((cmd_ff == amgs_pkg::CMD_IN_OUT) && !col_pass_ff) begin
                  col_pass_in = 1'b1;
                  idx_in      = '0;
               end else begin
                  if (nbr_cmd) begin
                     res_value_in = pend_valid_ff ? VB'(pend_idx_ff) + VB'(1) : '0;
                     res_empty_in = !pend_valid_ff;
                  end else begin
                     res_value_in = acc_ff;
                  end
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.value     = res_value_ff;
               rsp_data_in.last      = 1'b1;
               rsp_data_in.empty_res = res_empty_ff;
               rsp_data_in.error     = res_error_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      vertex_count_in = vertex_count_ff;
      edge_mode_in    = edge_mode_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            amgs_pkg::CSR_VERTEX_COUNT: vertex_count_in = csr_write_data;
            amgs_pkg::CSR_EDGE_MODE:    edge_mode_in = csr_write_data[amgs_pkg::EDGE_MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         clear_reply_ff  <= 1'b0;
         second_ff       <= 1'b0;
         col_pass_ff     <= 1'b0;
         idx_ff          <= '0;
         issued_ff       <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         vertex_count_ff <= amgs_pkg::VERTEX_COUNT_RESET;
         edge_mode_ff    <= amgs_pkg::EDGE_MODE_RESET;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         clear_reply_ff  <= clear_reply_in;
         second_ff       <= second_in;
         col_pass_ff     <= col_pass_in;
         idx_ff          <= idx_in;
         issued_ff       <= issued_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         vertex_count_ff <= vertex_count_in;
         edge_mode_ff    <= edge_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      didx_ff      <= didx_in;
      pend_idx_ff  <= pend_idx_in;
      acc_ff       <= acc_in;
      res_value_ff <= res_value_in;
      res_empty_ff <= res_empty_in;
      res_error_ff <= res_error_in;
      rsp_data_ff  <= rsp_data_in;
   end
endmodule

/* hdl/amgs_checker.sv */
// amgs_checker: port-level checks on the graph store, bound to the top level
// uses amgs_pkg; bind statement at the end of the file
module amgs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input amgs_pkg::rsp_payload_type rsp_payload
);
   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // errors only on a single final response with zero value and empty_res clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error |->
         rsp_payload.last && (rsp_payload.value == '0) && !rsp_payload.empty_res)
      else $error("error response malformed");

   // empty neighbour list is one final zero response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.empty_res |-> rsp_payload.last && (rsp_payload.value == '0))
      else $error("empty response malformed");

   // reset starts the clearing sweep, no commands taken
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("command taken during clearing sweep");
endmodule

bind adjacency_matrix_graph_store_core amgs_checker u_amgs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

/* sim/tb.sv */
// tb: self-checking bench for adjacency_matrix_graph_store_core, predicting every answer
// from a shadow copy of the edge-count matrix and the two registers
// depends on hdl/amgs_pkg.sv, hdl/amgs_stream_if.sv and the core itself
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import amgs_pkg::*;

   localparam int MAX_V       = 16;
   localparam int COUNT_W     = 8;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // shadow of the matrix and registers; holds the answers still owed by the core
   class edge_count_predictor;
      logic [COUNT_W-1:0]        counts [MAX_V][MAX_V];
      logic [VERTEX_BITS-1:0]    vertex_count;
      logic [EDGE_MODE_BITS-1:0] edge_mode;
      rsp_payload_type           pending_answers [$];
      int mismatches;
      int requests_seen;
      int answers_seen;
      int listings;
      int rejections;
      int saturated_adds;

      function new();
         clear_store();
         vertex_count = VERTEX_COUNT_RESET;
         edge_mode    = EDGE_MODE_RESET;
      endfunction

      function void clear_store();
         foreach (counts[r, c]) counts[r][c] = '0;
      endfunction

      function int active_vertices();
         return (vertex_count > MAX_V) ? MAX_V : int'(vertex_count);
      endfunction

      function bit vertex_valid(logic [VERTEX_BITS-1:0] v);
         return (v >= 1) && (v <= active_vertices());
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         if (index == CSR_VERTEX_COUNT) vertex_count = data;
         else edge_mode = data[EDGE_MODE_BITS-1:0];
      endfunction

      function void bump_count(int r, int c);
         if (counts[r][c] != COUNT_MAX) counts[r][c]++;
         else saturated_adds++;
      endfunction

      function logic [VALUE_BITS-1:0] clip_sum(int s);
         return (s > VALUE_MAX) ? VALUE_MAX : s[VALUE_BITS-1:0];
      endfunction

      function void owe(logic [VALUE_BITS-1:0] value, logic last, logic empty, logic err);
         rsp_payload_type item;
         item.value     = value;
         item.last      = last;
         item.empty_res = empty;
         item.error     = err;
         pending_answers.insert(pending_answers.size(), item);
      endfunction

      function void note_request(req_payload_type req);
         int  active;
         bit  need_col;
         int  r;
         int  c;
         int  row_total;
         int  col_total;
         int  hits;
         int  k;
         requests_seen++;
         active = active_vertices();
         if (req.command == CMD_CLEAR) begin
            clear_store();
            owe('0, 1'b1, 1'b0, 1'b0);
            return;
         end
         need_col = (req.command == CMD_ADD_EDGE) || (req.command == CMD_ADJACENT);
         if (!vertex_valid(req.row_vertex) ||
             (need_col && !vertex_valid(req.column_vertex))) begin
            rejections++;
            owe('0, 1'b1, 1'b0, 1'b1);
            return;
         end
         r = int'(req.row_vertex) - 1;
         c = need_col ? int'(req.column_vertex) - 1 : 0;
         row_total = 0;
         col_total = 0;
         for (int i = 0; i < active; i++) begin
            row_total += counts[r][i];
            col_total += counts[i][r];
         end
         case (req.command)
            CMD_ADD_EDGE: begin
               case (edge_mode)
                  MODE_SET_SYM: begin
                     counts[r][c] = COUNT_W'(1);
                     counts[c][r] = COUNT_W'(1);
                  end
                  MODE_SET_DIR: counts[r][c] = COUNT_W'(1);
                  MODE_INC_UNDIR: begin
                     // a loop is bumped once only
                     bump_count(r, c);
                     if (r != c) bump_count(c, r);
                  end
                  default: bump_count(r, c);
               endcase
               owe('0, 1'b1, 1'b0, 1'b0);
            end
            CMD_ADJACENT: owe(VALUE_BITS'(counts[r][c] != 0), 1'b1, 1'b0, 1'b0);
            CMD_DEGREE:   owe(clip_sum(row_total + counts[r][r]), 1'b1, 1'b0, 1'b0);
            CMD_IN_OUT:   owe(clip_sum(row_total + col_total), 1'b1, 1'b0, 1'b0);
            CMD_IN_DEG:   owe(clip_sum(col_total), 1'b1, 1'b0, 1'b0);
            CMD_OUT_DEG:  owe(clip_sum(row_total), 1'b1, 1'b0, 1'b0);
            default: begin
               listings++;
               hits = 0;
               for (int i = 0; i < active; i++) if (counts[r][i] != 0) hits++;
               if (hits == 0) owe('0, 1'b1, 1'b1, 1'b0);
               k = 0;
               for (int i = 0; i < active; i++) begin
                  if (counts[r][i] != 0) begin
                     k++;
                     owe(VALUE_BITS'(i + 1), (k == hits), 1'b0, 1'b0);
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            mismatches++;
            $display("%0t answer %0d: %s expected %0d actual %0d",
                     $time, answers_seen, field, want, got);
         end
      endfunction

      function void check_answer(rsp_payload_type got);
         rsp_payload_type want;
         answers_seen++;
         if (pending_answers.size() == 0) begin
            mismatches++;
            $display("%0t unexpected answer: expected none actual value %0d last %0b",
                     $time, got.value, got.last);
            return;
         end
         want = pending_answers.pop_front();
         compare_field("value", int'(want.value), int'(got.value));
         compare_field("last", int'(want.last), int'(got.last));
         compare_field("empty_res", int'(want.empty_res), int'(got.empty_res));
         compare_field("error", int'(want.error), int'(got.error));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   amgs_stream_if #(.payload_type(req_payload_type)) req_if ();
   amgs_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   adjacency_matrix_graph_store_core #(
      .MAX_VERTICES(MAX_V),
      .COUNT_BITS  (COUNT_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_if),
      .rsp_chan        (rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   edge_count_predictor model;
   int  quiet_cycles = 0;
   int  burst_left = 1;
   int  settings_used = 0;
   bit  offering = 0;
   bit  hold_armed = 0;
   bit  hold_done = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // transfers are sampled at the edge, before the nonblocking updates land
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) model.check_answer(rsp_if.payload);
         if (req_if.valid && req_if.ready) model.note_request(req_if.payload);
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t no transfer for %0d cycles, %0d answers outstanding",
                     $time, quiet_cycles, model.pending_answers.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // receiver: changing stall patterns, plus one long hold-off once armed
   initial begin
      int flavour;
      int stretch;
      rsp_if.ready = 1'b0;
      forever begin
         flavour = $urandom_range(0, 3);
         stretch = $urandom_range(20, 120);
         repeat (stretch) begin
            if (hold_armed && !hold_done) begin
               rsp_if.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_done = 1;
            end
            case (flavour)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= ($urandom_range(0, 7) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic offer_request(logic [COMMAND_BITS-1:0] cmd,
                                logic [VERTEX_BITS-1:0] row,
                                logic [VERTEX_BITS-1:0] col);
      req_payload_type item;
      item.command       = cmd;
      item.row_vertex    = row;
      item.column_vertex = col;
      req_if.payload <= item;
      req_if.valid   <= 1'b1;
      offering = 1;
      do @(posedge clock); while (!req_if.ready);
      // bursts of random length with gaps between them
      burst_left--;
      if (burst_left <= 0) begin
         req_if.valid <= 1'b0;
         offering = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 6);
      end
   endtask

   task automatic settle();
      if (offering) req_if.valid <= 1'b0;
      offering = 0;
      @(posedge clock);
      while (model.pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(logic [VERTEX_BITS-1:0] count,
                               logic [EDGE_MODE_BITS-1:0] mode);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_VERTEX_COUNT;
      csr_write_data   <= count;
      @(posedge clock);
      csr_index      <= CSR_EDGE_MODE;
      csr_write_data <= CSR_DATA_BITS'(mode);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model.write_register(CSR_VERTEX_COUNT, count);
      model.write_register(CSR_EDGE_MODE, CSR_DATA_BITS'(mode));
      settings_used++;
   endtask

   function automatic logic [COMMAND_BITS-1:0] pick_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)  return CMD_CLEAR;
      if (roll < 38) return CMD_ADD_EDGE;
      if (roll < 50) return CMD_ADJACENT;
      if (roll < 58) return CMD_DEGREE;
      if (roll < 65) return CMD_IN_OUT;
      if (roll < 72) return CMD_IN_DEG;
      if (roll < 79) return CMD_OUT_DEG;
      return CMD_NEIGHBORS;
   endfunction

   function automatic logic [VERTEX_BITS-1:0] pick_vertex();
      int active;
      active = model.active_vertices();
      if (active == 0 || $urandom_range(0, 99) < 12)
         return VERTEX_BITS'($urandom_range(0, MAX_V));
      return VERTEX_BITS'($urandom_range(1, active));
   endfunction

   task automatic run_random(int items);
      repeat (items) offer_request(pick_command(), pick_vertex(), pick_vertex());
      settle();
   endtask

   // reset settings: 16 vertices, undirected increments
   task automatic run_directed();
      offer_request(CMD_CLEAR, 0, 0);
      offer_request(CMD_ADD_EDGE, 1, 1);
      offer_request(CMD_ADD_EDGE, 1, 16);
      offer_request(CMD_ADD_EDGE, 16, 1);
      offer_request(CMD_ADD_EDGE, 5, 9);
      offer_request(CMD_ADD_EDGE, 0, 3);
      offer_request(CMD_ADD_EDGE, 3, 0);
      offer_request(CMD_ADJACENT, 1, 16);
      offer_request(CMD_ADJACENT, 1, 1);
      offer_request(CMD_ADJACENT, 2, 3);
      offer_request(CMD_ADJACENT, 16, 0);
      offer_request(CMD_DEGREE, 1, 0);
      offer_request(CMD_DEGREE, 0, 1);
      offer_request(CMD_IN_OUT, 16, 5);
      offer_request(CMD_IN_DEG, 1, 1);
      offer_request(CMD_OUT_DEG, 16, 16);
      offer_request(CMD_NEIGHBORS, 1, 0);
      offer_request(CMD_NEIGHBORS, 2, 0);
      offer_request(CMD_NEIGHBORS, 0, 0);
      offer_request(CMD_NEIGHBORS, 16, 16);
      settle();
   endtask

   // hammer one vertex pair and its loops, then query, switch modes and overwrite it
   task automatic run_repeats();
      logic [VERTEX_BITS-1:0] row;
      logic [VERTEX_BITS-1:0] col;
      write_config(2, MODE_INC_UNDIR);
      offer_request(CMD_CLEAR, 0, 0);
      repeat (20) begin
         row = 5'd1 + VERTEX_BITS'($urandom_range(0, 1));
         col = ($urandom_range(0, 3) == 0) ? row : 5'd3 - row;
         offer_request(CMD_ADD_EDGE, row, col);
      end
      offer_request(CMD_DEGREE, 1, 0);
      offer_request(CMD_DEGREE, 2, 0);
      offer_request(CMD_IN_OUT, 1, 0);
      offer_request(CMD_IN_DEG, 2, 0);
      offer_request(CMD_OUT_DEG, 1, 0);
      offer_request(CMD_ADJACENT, 2, 1);
      offer_request(CMD_NEIGHBORS, 2, 0);
      offer_request(CMD_ADD_EDGE, 3, 1);
      offer_request(CMD_NEIGHBORS, 3, 0);
      settle();
      write_config(2, MODE_INC_DIR);
      repeat (4) offer_request(CMD_ADD_EDGE, 1, 2);
      repeat (4) offer_request(CMD_ADD_EDGE, 1, 1);
      offer_request(CMD_OUT_DEG, 1, 0);
      offer_request(CMD_IN_OUT, 2, 0);
      settle();
      write_config(2, MODE_SET_SYM);
      offer_request(CMD_ADD_EDGE, 1, 2);
      offer_request(CMD_DEGREE, 1, 0);
      offer_request(CMD_NEIGHBORS, 2, 0);
      settle();
   endtask

   initial begin
      model = new();
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      write_config(16, MODE_SET_SYM);
      run_random(25);
      write_config(1, MODE_SET_DIR);
      run_random(10);
      // no vertex is valid with a zero count
      write_config(0, MODE_INC_DIR);
      run_random(8);
      // a count above the matrix size acts as the full size
      write_config(31, MODE_INC_DIR);
      hold_armed = 1;
      run_random(30);
      write_config(7, MODE_INC_UNDIR);
      run_random(25);
      run_repeats();

      repeat (40) @(posedge clock);
      $display("%0d requests and %0d answers checked over %0d register settings",
               model.requests_seen, model.answers_seen, settings_used);
      $display("%0d neighbour listings, %0d out-of-range rejections, %0d adds at the ceiling",
               model.listings, model.rejections, model.saturated_adds);
      if (model.mismatches == 0 && model.pending_answers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* adjacency_matrix_graph_store_core.f */
hdl/amgs_pkg.sv
hdl/amgs_stream_if.sv
hdl/amgs_count_ram.sv
hdl/adjacency_matrix_graph_store_core.sv
hdl/amgs_checker.sv
sim/tb.sv
